### rtl/core/cfpe_pkg.sv
// shared types, constants and the crc-16 byte fold for the frame encoder
package cfpe_pkg;

   // frame size limit and fixed frame overhead (sync, type, length, crc)
   localparam int unsigned MAX_FRAME = 1024;
   localparam int unsigned OVERHEAD  = 7;

   // crc-16/ccitt-false
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_SEED = 16'hFFFF;

   // header reset values
   localparam logic [7:0] HEADER_FIRST_RESET  = 8'hAA;
   localparam logic [7:0] HEADER_SECOND_RESET = 8'h55;

   // input word kinds
   localparam logic KIND_START   = 1'b0;
   localparam logic KIND_PAYLOAD = 1'b1;

   // register indexes
   localparam logic CSR_HEADER_FIRST  = 1'b0;
   localparam logic CSR_HEADER_SECOND = 1'b1;

   // position of one output byte within the frame
   typedef enum logic [2:0] {
      SLOT_HDR1   = 3'd0,
      SLOT_HDR2   = 3'd1,
      SLOT_TYPE   = 3'd2,
      SLOT_LEN_LO = 3'd3,
      SLOT_LEN_HI = 3'd4,
      SLOT_CRC_LO = 3'd5,
      SLOT_CRC_HI = 3'd6,
      SLOT_DATA   = 3'd7
   } slot_type;

   // byte run that one accepted word produces
   typedef struct packed {
      logic        valid;
      logic        err;
      slot_type    first;
      slot_type    last;
      logic [7:0]  frame_type;
      logic [15:0] len;
      logic [7:0]  pb;
      logic [15:0] crc;
   } plan_type;

   // fold one byte into the crc, msb first
   function automatic logic [15:0] crc_fold(input logic [15:0] crc_in, input logic [7:0] data);
      logic [15:0] c;
      c = crc_in ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

### rtl/core/cfpe_frame_ctl.sv
// frame state: open flag, bytes still expected, running crc; plans each word's byte run
module cfpe_frame_ctl #(
   parameter int unsigned MAX_FRAME = cfpe_pkg::MAX_FRAME
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic                kind,
   input  logic [7:0]          frame_type,
   input  logic [15:0]         payload_length,
   input  logic [7:0]          payload_byte,
   output cfpe_pkg::plan_type  plan
);
   import cfpe_pkg::*;

   logic        in_frame_ff, in_frame_in;
   logic [15:0] bytes_left_ff, bytes_left_in;
   logic [15:0] crc_ff, crc_in;

   logic        too_large;
   logic [15:0] crc_next;
   logic [15:0] left_dec;

   // length check against the frame limit
   assign too_large = ({1'b0, payload_length} + 17'(OVERHEAD)) > 17'(MAX_FRAME);
   assign crc_next  = crc_fold(crc_ff, payload_byte);
   assign left_dec  = bytes_left_ff - 16'd1;

   // byte run for the presented word
   always_comb begin
      plan            = '0;
      plan.frame_type = frame_type;
      plan.len        = payload_length;
      plan.pb         = payload_byte;
      plan.first      = SLOT_HDR1;
      plan.last       = SLOT_HDR1;
      plan.crc        = CRC_SEED;
      if (kind == KIND_START) begin
         plan.valid = 1'b1;
         plan.err   = too_large;
         if (!too_large) begin
            plan.last = (payload_length == 16'd0) ? SLOT_CRC_HI : SLOT_LEN_HI;
         end
      end else begin
         plan.valid = in_frame_ff;
         plan.first = SLOT_DATA;
         plan.last  = (left_dec == 16'd0) ? SLOT_CRC_HI : SLOT_DATA;
         plan.crc   = crc_next;
      end
   end

   // next frame state
   always_comb begin
      in_frame_in   = in_frame_ff;
      bytes_left_in = bytes_left_ff;
      crc_in        = crc_ff;
      if (accept) begin
         if (kind == KIND_START) begin
            if (too_large) begin
               in_frame_in   = 1'b0;
               bytes_left_in = 16'd0;
            end else begin
               crc_in        = CRC_SEED;
               in_frame_in   = (payload_length != 16'd0);
               bytes_left_in = payload_length;
            end
         end else if (in_frame_ff) begin
            crc_in        = crc_next;
            bytes_left_in = left_dec;
            in_frame_in   = (left_dec != 16'd0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff   <= 1'b0;
         bytes_left_ff <= 16'd0;
         crc_ff        <= CRC_SEED;
      end else begin
         in_frame_ff   <= in_frame_in;
         bytes_left_ff <= bytes_left_in;
         crc_ff        <= crc_in;
      end
   end

endmodule

### rtl/core/cfpe_byte_seq.sv
// holding register for one planned run and the output register sending it a byte a cycle unless stalled
module cfpe_byte_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  cfpe_pkg::plan_type  plan,
   input  logic [7:0]          header_first,
   input  logic [7:0]          header_second,
   output logic                hold_free,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,
   output logic                rsp_tlast,
   output logic [1:0]          rsp_tuser
);
   import cfpe_pkg::*;

   logic        hold_valid_ff, hold_valid_in;
   slot_type    slot_ff, slot_in;
   slot_type    last_ff, last_in;
   logic        err_ff, err_in;
   logic [7:0]  type_ff, type_in;
   logic [15:0] len_ff, len_in;
   logic [7:0]  pb_ff, pb_in;
   logic [15:0] crc_ff, crc_in;

   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic        out_end_ff, out_end_in;
   logic        out_big_ff, out_big_in;
   logic        out_last_ff, out_last_in;

   logic        out_load;
   logic        retire;
   logic        is_last;
   logic        take;
   slot_type    slot_step;
   logic [7:0]  slot_byte;

   assign out_load  = hold_valid_ff && (!out_valid_ff || rsp_tready);
   assign is_last   = (slot_ff == last_ff);
   assign retire    = out_load && is_last;
   assign hold_free = !hold_valid_ff || retire;
   assign take      = accept && plan.valid;

   // slot order: header bytes, then crc after the length or after a data byte
   always_comb begin
      if (slot_ff == SLOT_DATA) begin
         slot_step = SLOT_CRC_LO;
      end else begin
         slot_step = slot_type'(slot_ff + 3'd1);
      end
   end

   // byte for the current slot
   always_comb begin
      unique case (slot_ff)
         SLOT_HDR1:   slot_byte = header_first;
         SLOT_HDR2:   slot_byte = header_second;
         SLOT_TYPE:   slot_byte = type_ff;
         SLOT_LEN_LO: slot_byte = len_ff[7:0];
         SLOT_LEN_HI: slot_byte = len_ff[15:8];
         SLOT_CRC_LO: slot_byte = crc_ff[7:0];
         SLOT_CRC_HI: slot_byte = crc_ff[15:8];
         SLOT_DATA:   slot_byte = pb_ff;
         default:     slot_byte = 8'h00;
      endcase
   end

   // holding register
   always_comb begin
      hold_valid_in = hold_valid_ff;
      slot_in       = slot_ff;
      last_in       = last_ff;
      err_in        = err_ff;
      type_in       = type_ff;
      len_in        = len_ff;
      pb_in         = pb_ff;
      crc_in        = crc_ff;
      if (take) begin
         hold_valid_in = 1'b1;
         slot_in       = plan.first;
         last_in       = plan.err ? plan.first : plan.last;
         err_in        = plan.err;
         type_in       = plan.frame_type;
         len_in        = plan.len;
         pb_in         = plan.pb;
         crc_in        = plan.crc;
      end else if (retire) begin
         hold_valid_in = 1'b0;
      end else if (out_load) begin
         slot_in = slot_step;
      end
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_end_in   = out_end_ff;
      out_big_in   = out_big_ff;
      out_last_in  = out_last_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
         out_byte_in  = err_ff ? 8'h00 : slot_byte;
         out_end_in   = !err_ff && (slot_ff == SLOT_CRC_HI);
         out_big_in   = err_ff;
         out_last_in  = is_last;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff     <= slot_in;
      last_ff     <= last_in;
      err_ff      <= err_in;
      type_ff     <= type_in;
      len_ff      <= len_in;
      pb_ff       <= pb_in;
      crc_ff      <= crc_in;
      out_byte_ff <= out_byte_in;
      out_end_ff  <= out_end_in;
      out_big_ff  <= out_big_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_end_ff;
   assign rsp_tuser  = {out_last_ff, out_big_ff};

endmodule

### rtl/core/crc16_framed_packet_encoder.sv
// top level of the length-prefixed frame encoder with crc-16 trailer
// Sends one encoded byte per cycle, while the receiver is ready, through a single
// output register. A payload word yields one byte (three for the last byte of a
// frame, which adds the two crc bytes); a start word yields five bytes, seven for
// an empty payload, and an oversized start (payload length plus seven above
// MAX_FRAME) yields one zero byte. A new word is taken in the same cycle that the
// previous word's final byte moves to the output. Payload words with no frame
// open are absorbed with no output. The user must write the sync bytes through
// the csr port only while the block is idle; the block has no guard for it.
module crc16_framed_packet_encoder #(
   parameter int unsigned MAX_FRAME = cfpe_pkg::MAX_FRAME
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // frame_type[7:0], payload_length[23:8], payload_byte[31:24]
   input  logic        req_tuser,   // kind[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_byte[7:0]
   output logic        rsp_tlast,   // frame_end
   output logic [1:0]  rsp_tuser,   // too_large[0], run_last[1]
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);
   import cfpe_pkg::*;

   logic       accept;
   plan_type   plan;
   logic [7:0] header_first_ff, header_first_in;
   logic [7:0] header_second_ff, header_second_in;

   assign accept = req_tvalid && req_tready;

   // sync byte registers
   always_comb begin
      header_first_in  = header_first_ff;
      header_second_in = header_second_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_HEADER_FIRST:  header_first_in  = csr_wdata;
            CSR_HEADER_SECOND: header_second_in = csr_wdata;
            default:           header_first_in  = header_first_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_first_ff  <= HEADER_FIRST_RESET;
         header_second_ff <= HEADER_SECOND_RESET;
      end else begin
         header_first_ff  <= header_first_in;
         header_second_ff <= header_second_in;
      end
   end

   cfpe_frame_ctl #(
      .MAX_FRAME (MAX_FRAME)
   ) u_frame_ctl (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .kind           (req_tuser),
      .frame_type     (req_tdata[7:0]),
      .payload_length (req_tdata[23:8]),
      .payload_byte   (req_tdata[31:24]),
      .plan           (plan)
   );

   cfpe_byte_seq u_byte_seq (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .plan          (plan),
      .header_first  (header_first_ff),
      .header_second (header_second_ff),
      .hold_free     (req_tready),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .rsp_tuser     (rsp_tuser)
   );

endmodule

### rtl/core/cfpe_checker.sv
// port-level checks for the frame encoder, bound to the top level
module cfpe_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic        rsp_tlast,
   input logic [1:0]  rsp_tuser
);

   // a stalled output word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("output word changed under back-pressure");

   // an oversize error is a lone zero word ending its run
   a_err_word: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tuser[1] && !rsp_tlast && (rsp_tdata == 8'h00))
      else $error("malformed oversize error word");

   // the last crc byte always closes the run of its input word
   a_end_closes_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser[1] && !rsp_tuser[0])
      else $error("frame end without run end");

   // nothing is left in the output after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("output valid straight after reset");

endmodule

bind crc16_framed_packet_encoder cfpe_checker u_cfpe_checker (.*);

### sim/tb_crc16_framed_packet_encoder.sv
// self-checking testbench for the crc-16 framed packet encoder
module tb_crc16_framed_packet_encoder;
   timeunit 1ns;
   timeprecision 1ps;

   import cfpe_pkg::*;

   localparam int HOLD_CYCLES  = 80;   // long receiver hold-off
   localparam int HOLD_EVERY   = 120;  // words between hold-offs
   localparam int DRAIN_CYCLES = 10;   // settle time after the last byte
   localparam int PHASE_WORDS  = 60;

   // one input word, with an optional hand-written expectation
   typedef struct packed {
      logic        kind;
      logic [7:0]  frame_type;
      logic [15:0] payload_length;
      logic [7:0]  payload_byte;
      logic        typed;
      logic [2:0]  typed_n;
      logic [55:0] typed_bytes;   // first byte in the highest used bits
      logic        typed_err;
      logic        typed_end;
   } word_t;

   // one output byte with its flags
   typedef struct packed {
      logic [7:0] out_byte;
      logic       frame_end;
      logic       too_large;
      logic       run_last;
   } result_t;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_tvalid     = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata      = '0;   // frame_type, payload_length, payload_byte
   logic        req_tuser      = KIND_START;   // kind
   logic        rsp_tvalid;
   logic        rsp_tready     = 1'b0;
   logic [7:0]  rsp_tdata;              // out_byte
   logic        rsp_tlast;              // frame_end
   logic [1:0]  rsp_tuser;              // too_large, run_last
   logic        csr_we         = 1'b0;
   logic        csr_index      = CSR_HEADER_FIRST;
   logic [7:0]  csr_wdata      = '0;

   // encoder model state
   logic [7:0]  hdr_first      = HEADER_FIRST_RESET;
   logic [7:0]  hdr_second     = HEADER_SECOND_RESET;
   logic        frame_open     = 1'b0;
   logic [15:0] remaining      = '0;
   logic [15:0] crc_acc        = CRC_SEED;

   word_t       cur_word       = '0;
   word_t       pending_words[$];
   word_t       directed_rows[$];
   result_t     word_bytes[$];
   result_t     expected_bytes[$];
   int          error_count    = 0;
   int          words_accepted = 0;

   // receiver pattern state
   int          hold_left      = 0;
   int          next_hold_at   = 40;
   logic [15:0] rx_cycle       = '0;
   logic [1:0]  rx_mode        = '0;

   crc16_framed_packet_encoder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // 20 ns clock
   always #10 clock = ~clock;

   // crc-16 ccitt, one message bit at a time
   function automatic logic [15:0] crc_next(input logic [15:0] crc_in, input logic [7:0] data);
      logic [15:0] r;
      logic        fb;
      r = crc_in;
      for (int i = 7; i >= 0; i--) begin
         fb = r[15] ^ data[i];
         r  = {r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
      end
      return r;
   endfunction

   function automatic void add_byte(input logic [7:0] b, input logic fend, input logic big);
      result_t r;
      r.out_byte  = b;
      r.frame_end = fend;
      r.too_large = big;
      r.run_last  = 1'b0;
      word_bytes.push_back(r);
   endfunction

   function automatic void close_frame();
      add_byte(crc_acc[7:0], 1'b0, 1'b0);
      add_byte(crc_acc[15:8], 1'b1, 1'b0);
      frame_open = 1'b0;
      remaining  = '0;
   endfunction

   // bytes that one accepted word produces, and the state it leaves
   function automatic void encode_word(input word_t w);
      word_bytes.delete();
      if (w.kind == KIND_START) begin
         if (w.payload_length + OVERHEAD > MAX_FRAME) begin
            frame_open = 1'b0;
            remaining  = '0;
            add_byte(8'h00, 1'b0, 1'b1);
         end else begin
            add_byte(hdr_first, 1'b0, 1'b0);
            add_byte(hdr_second, 1'b0, 1'b0);
            add_byte(w.frame_type, 1'b0, 1'b0);
            add_byte(w.payload_length[7:0], 1'b0, 1'b0);
            add_byte(w.payload_length[15:8], 1'b0, 1'b0);
            crc_acc = CRC_SEED;
            if (w.payload_length == 16'd0) begin
               close_frame();
            end else begin
               frame_open = 1'b1;
               remaining  = w.payload_length;
            end
         end
      end else if (frame_open) begin
         crc_acc = crc_next(crc_acc, w.payload_byte);
         add_byte(w.payload_byte, 1'b0, 1'b0);
         remaining = remaining - 16'd1;
         if (remaining == 16'd0) begin
            close_frame();
         end
      end
      if (word_bytes.size() > 0) begin
         word_bytes[word_bytes.size() - 1].run_last = 1'b1;
      end
   endfunction

   function automatic word_t start_word(input logic [7:0] ftype, input logic [15:0] len);
      word_t w;
      w                = '0;
      w.kind           = KIND_START;
      w.frame_type     = ftype;
      w.payload_length = len;
      w.payload_byte   = 8'($urandom_range(0, 255));
      return w;
   endfunction

   function automatic word_t payload_word(input logic [7:0] pb);
      word_t w;
      w                = '0;
      w.kind           = KIND_PAYLOAD;
      w.frame_type     = 8'($urandom_range(0, 255));
      w.payload_length = 16'($urandom_range(0, 65535));
      w.payload_byte   = pb;
      return w;
   endfunction

   // hand-written expectations for the table
   function automatic word_t with_bytes(input word_t w, input int n, input logic [55:0] bytes,
                                        input logic fend);
      w.typed       = 1'b1;
      w.typed_n     = 3'(n);
      w.typed_bytes = bytes;
      w.typed_end   = fend;
      return w;
   endfunction

   function automatic word_t with_error(input word_t w);
      w.typed     = 1'b1;
      w.typed_err = 1'b1;
      return w;
   endfunction

   function automatic word_t with_none(input word_t w);
      w.typed = 1'b1;
      return w;
   endfunction

   // mostly well-formed frames with random content, some noise and cut-off frames
   task automatic queue_random_words(input int count);
      int made;
      int r;
      int len;
      int sent;
      made = 0;
      while (made < count) begin
         r = $urandom_range(0, 99);
         if (r < 6) begin
            pending_words.push_back(start_word(8'($urandom_range(0, 255)),
               16'($urandom_range(MAX_FRAME - OVERHEAD + 1, 65535))));
            made++;
         end else if (r < 12) begin
            // stray byte, absorbed unless a cut-off frame is still open
            pending_words.push_back(payload_word(8'($urandom_range(0, 255))));
         end else begin
            len  = (r < 22) ? $urandom_range(13, 64) : $urandom_range(0, 12);
            sent = (r >= 88 && len > 0) ? $urandom_range(0, len - 1) : len;
            pending_words.push_back(start_word(8'($urandom_range(0, 255)), 16'(len)));
            for (int k = 0; k < sent; k++) begin
               pending_words.push_back(payload_word(8'($urandom_range(0, 255))));
            end
            made += 1 + sent;
         end
      end
   endtask

   // sender: bursts of random length with random gaps
   task automatic send_words();
      word_t w;
      int    burst_left;
      burst_left = 0;
      while (pending_words.size() > 0) begin
         if (burst_left == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
         end
         w = pending_words.pop_front();
         req_tvalid <= 1'b1;
         req_tuser  <= w.kind;
         req_tdata  <= {w.payload_byte, w.payload_length, w.frame_type};
         cur_word   <= w;
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         burst_left--;
      end
      req_tvalid <= 1'b0;
   endtask

   // wait until every expected byte has come out and the block has settled
   task automatic drain();
      @(posedge clock);
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_headers(input logic [7:0] first, input logic [7:0] second);
      csr_we    <= 1'b1;
      csr_index <= CSR_HEADER_FIRST;
      csr_wdata <= first;
      @(posedge clock);
      csr_index <= CSR_HEADER_SECOND;
      csr_wdata <= second;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // receiver: changing stall pattern plus periodic long hold-offs
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (words_accepted >= next_hold_at) begin
         hold_left    <= HOLD_CYCLES;
         next_hold_at <= next_hold_at + HOLD_EVERY;
         rsp_tready   <= 1'b0;
      end else begin
         rx_cycle <= rx_cycle + 16'd1;
         if (rx_cycle[4:0] == 5'd0) begin
            rx_mode <= 2'($urandom_range(0, 3));
         end
         case (rx_mode)
            2'd0: rsp_tready <= 1'b1;
            2'd1: rsp_tready <= ($urandom_range(0, 3) != 0);
            2'd2: rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= rx_cycle[0];
         endcase
      end
   end

   // model update on csr writes and accepted words, check of every output word
   always @(posedge clock) begin : monitor
      result_t got;
      result_t want;
      if (!reset) begin
         if (csr_we) begin
            case (csr_index)
               CSR_HEADER_FIRST:  hdr_first  = csr_wdata;
               CSR_HEADER_SECOND: hdr_second = csr_wdata;
            endcase
         end
         if (req_tvalid && req_tready) begin
            words_accepted <= words_accepted + 1;
            encode_word(cur_word);
            if (!cur_word.typed) begin
               foreach (word_bytes[i]) expected_bytes.push_back(word_bytes[i]);
            end else if (cur_word.typed_err) begin
               want = '{out_byte: 8'h00, frame_end: 1'b0, too_large: 1'b1, run_last: 1'b1};
               expected_bytes.push_back(want);
            end else begin
               for (int k = 0; k < cur_word.typed_n; k++) begin
                  want.out_byte  = cur_word.typed_bytes[8 * (cur_word.typed_n - 1 - k) +: 8];
                  want.run_last  = (k == cur_word.typed_n - 1);
                  want.frame_end = cur_word.typed_end && want.run_last;
                  want.too_large = 1'b0;
                  expected_bytes.push_back(want);
               end
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got = '{out_byte: rsp_tdata, frame_end: rsp_tlast, too_large: rsp_tuser[0],
                    run_last: rsp_tuser[1]};
            if (expected_bytes.size() == 0) begin
               $display("%0t: unexpected word byte=%02h end=%b big=%b last=%b", $realtime,
                        got.out_byte, got.frame_end, got.too_large, got.run_last);
               error_count++;
            end else begin
               want = expected_bytes.pop_front();
               if (got.out_byte !== want.out_byte || got.frame_end !== want.frame_end ||
                   got.too_large !== want.too_large || got.run_last !== want.run_last) begin
                  $display("%0t: mismatch exp byte=%02h end=%b big=%b last=%b, act byte=%02h end=%b big=%b last=%b",
                           $realtime, want.out_byte, want.frame_end, want.too_large,
                           want.run_last, got.out_byte, got.frame_end, got.too_large,
                           got.run_last);
                  error_count++;
               end
            end
         end
      end
   end

   // run limit
   initial begin : watchdog
      #(2_000_000);
      $display("CHECK FAILED");
      $finish;
   end

   // stimulus
   initial begin : stimulus
      // directed table, sync bytes at reset values
      directed_rows.push_back(with_none(payload_word(8'h5A)));
      directed_rows.push_back(with_bytes(start_word(8'h00, 16'd0), 7,
                                         56'hAA_55_00_00_00_FF_FF, 1'b1));
      directed_rows.push_back(with_bytes(start_word(8'hFF, 16'd1017), 5,
                                         56'hAA_55_FF_F9_03, 1'b0));
      directed_rows.push_back(with_error(start_word(8'h3C, 16'd1018)));
      directed_rows.push_back(with_none(payload_word(8'hFF)));
      directed_rows.push_back(with_error(start_word(8'hA5, 16'hFFFF)));
      directed_rows.push_back(start_word(8'h81, 16'd3));
      directed_rows.push_back(payload_word(8'h00));
      directed_rows.push_back(payload_word(8'hFF));
      directed_rows.push_back(payload_word(8'h80));
      // new start abandons the open frame without its crc
      directed_rows.push_back(start_word(8'h12, 16'd2));
      directed_rows.push_back(payload_word(8'h31));
      directed_rows.push_back(start_word(8'h34, 16'd1));
      directed_rows.push_back(payload_word(8'h7E));
      // standard check string, crc 29b1
      directed_rows.push_back(start_word(8'hC3, 16'd9));
      for (int k = 1; k < 9; k++) begin
         directed_rows.push_back(payload_word(8'h30 + 8'(k)));
      end
      directed_rows.push_back(with_bytes(payload_word(8'h39), 3, 56'h39_B1_29, 1'b1));

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) pending_words.push_back(directed_rows[i]);
      send_words();
      queue_random_words(PHASE_WORDS);
      send_words();
      drain();

      // sync byte extremes, then random settings
      write_headers(8'h00, 8'hFF);
      queue_random_words(PHASE_WORDS);
      send_words();
      drain();

      write_headers(8'hFF, 8'h00);
      queue_random_words(PHASE_WORDS);
      send_words();
      drain();

      write_headers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      queue_random_words(PHASE_WORDS);
      send_words();
      drain();

      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

### files.f
rtl/core/cfpe_pkg.sv
rtl/core/cfpe_frame_ctl.sv
rtl/core/cfpe_byte_seq.sv
rtl/core/crc16_framed_packet_encoder.sv
rtl/core/cfpe_checker.sv
sim/tb_crc16_framed_packet_encoder.sv
